/* hw/rtl/albd_pkg.sv */
`timescale 1ns / 1ps
package albd_pkg;

  // One audio sample with its batch marker and timestamp.
  typedef struct packed {
    logic signed [15:0] sample;
    logic               batch_end;
    logic [31:0]        time_ms;
  } albd_in_t;

  // One batch result.
  typedef struct packed {
    logic [15:0] level_raw;
    logic [15:0] level_smooth;
    logic [15:0] peak_level;
    logic        beat;
    logic [15:0] gain_now;
  } albd_out_t;

  // Configuration register indexes.
  localparam logic [3:0] REG_AGC_ENABLE  = 4'd0;
  localparam logic [3:0] REG_TARGET_HIGH = 4'd1;
  localparam logic [3:0] REG_TARGET_LOW  = 4'd2;
  localparam logic [3:0] REG_ATTACK_RATE = 4'd3;
  localparam logic [3:0] REG_DECAY_RATE  = 4'd4;
  localparam logic [3:0] REG_GAIN_FLOOR  = 4'd5;
  localparam logic [3:0] REG_GAIN_CEIL   = 4'd6;
  localparam logic [3:0] REG_BEAT_HOLD   = 4'd7;

  localparam logic [15:0] LEVEL_MAX    = 16'd65280;
  localparam logic [15:0] AGC_MIN_LVL  = 16'd64;
  localparam logic [15:0] UNITY_GAIN   = 16'd1024;
  localparam int          WORK_W       = 56;

endpackage

/* hw/rtl/audio_level_agc_beat_detector_top.sv */
`timescale 1ns / 1ps
// RMS level meter with automatic gain and beat detection. A sample is taken when start_i is
// high and busy_o is low; an ordinary sample keeps busy_o high while its square is
// accumulated. The sample marked batch_end closes the batch and keeps the block busy while
// these steps run in order: the sample is taken, the sum is scaled, a bit-serial divider forms
// the mean square, a shared bit-serial square root runs twice (level, then peak), the gain
// update runs when the automatic gain applies, and smoothing, baseline and beat logic run.
// result_valid_o is then high for exactly one cycle with the result on result_o; the receiver
// cannot stall it. Configuration writes are always accepted and should be made while the
// block is idle.
module audio_level_agc_beat_detector_top #(
  parameter int BATCH_SAMPLES = 320
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  albd_pkg::albd_in_t  item_i,
  output logic                result_valid_o,
  output albd_pkg::albd_out_t result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [3:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);
  import albd_pkg::*;

  localparam int TW = $clog2(BATCH_SAMPLES + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ACC      = 4'd1;
  localparam logic [3:0] S_SCALE    = 4'd2;
  localparam logic [3:0] S_DIV      = 4'd3;
  localparam logic [3:0] S_SQRT_LVL = 4'd4;
  localparam logic [3:0] S_SQRT_PK  = 4'd5;
  localparam logic [3:0] S_GAIN_MUL = 4'd6;
  localparam logic [3:0] S_CLAMP    = 4'd7;
  localparam logic [3:0] S_STEP_MUL = 4'd8;
  localparam logic [3:0] S_GAIN_UPD = 4'd9;
  localparam logic [3:0] S_SMOOTH   = 4'd10;
  localparam logic [3:0] S_BASE     = 4'd11;
  localparam logic [3:0] S_BEAT     = 4'd12;

  logic [3:0]  state_q;
  albd_in_t    smp_q;
  logic [39:0] sum_q;
  logic [30:0] peak_q;
  logic [TW-1:0] tally_q;
  logic [15:0] gain_q;
  logic [23:0] smooth_q, base_q;
  logic [31:0] last_q;

  logic        agc_en_q;
  logic [15:0] high_q, low_q, attack_q, decay_q, floor_q, ceil_q, hold_q;

  logic [WORK_W-1:0] num_q, rad_q, root_q, bit_q;
  logic [TW-1:0]     rem_q;
  logic [5:0]        cnt_q;
  logic [15:0]       level_q, pk_lvl_q, proc_q;
  logic [31:0]       prod_q;
  logic              dir_dn_q;

  logic        res_valid_q;
  albd_out_t   res_q;

  assign busy_o         = (state_q != S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // Accumulation terms for the held sample.
  logic [30:0] sq;
  logic [40:0] sum_add;
  always_comb begin
    sq      = 31'($signed(smp_q.sample) * $signed(smp_q.sample));
    sum_add = {1'b0, sum_q} + 41'(sq);
  end

  // One restoring division step.
  logic [TW:0]       trial;
  logic [TW-1:0]     divisor, rem_d;
  logic [WORK_W-1:0] num_d;
  always_comb begin
    divisor = (tally_q == '0) ? TW'(1) : tally_q;
    trial   = {rem_q, num_q[WORK_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_d = TW'(trial - {1'b0, divisor});
      num_d = {num_q[WORK_W-2:0], 1'b1};
    end else begin
      rem_d = trial[TW-1:0];
      num_d = {num_q[WORK_W-2:0], 1'b0};
    end
  end

  // One square root step, shared by the level and the peak.
  logic [WORK_W:0]   rb;
  logic [WORK_W-1:0] rad_d, root_d;
  logic [WORK_W-8:0] root_scaled;
  logic [15:0]       sqrt_lvl;
  always_comb begin
    rb = {1'b0, root_q} + {1'b0, bit_q};
    if ({1'b0, rad_q} >= rb) begin
      rad_d  = rad_q - rb[WORK_W-1:0];
      root_d = (root_q >> 1) + bit_q;
    end else begin
      rad_d  = rad_q;
      root_d = root_q >> 1;
    end
    root_scaled = root_d[WORK_W-1:7];
    sqrt_lvl    = (root_scaled > (WORK_W-7)'(LEVEL_MAX)) ? LEVEL_MAX : root_scaled[15:0];
  end

  // Peak square times 65025, as shifts and adds.
  logic [WORK_W-1:0] pk_scaled, sum_scaled;
  always_comb begin
    pk_scaled  = (WORK_W'(peak_q) << 16) - (WORK_W'(peak_q) << 9) + WORK_W'(peak_q);
    sum_scaled = (WORK_W'(sum_q) << 16) - (WORK_W'(sum_q) << 9) + WORK_W'(sum_q);
  end

  // Gain update, smoothing and beat terms.
  logic [21:0]        proc_wide;
  logic signed [19:0] g_new;
  logic signed [25:0] sm_diff, bs_diff;
  logic signed [39:0] sm_prod, bs_prod;
  logic [23:0]        smooth_new, base_new;
  logic [26:0]        smooth_x5;
  logic [27:0]        base_x9;
  logic [31:0]        elapsed;
  logic               beat_now;
  always_comb begin
    proc_wide = prod_q[31:10];
    if (dir_dn_q) begin
      g_new = $signed({4'd0, gain_q}) - $signed({2'd0, prod_q[31:14]});
    end else begin
      g_new = $signed({4'd0, gain_q}) + $signed({2'd0, prod_q[31:14]});
    end
    if (g_new < $signed({4'd0, floor_q})) g_new = $signed({4'd0, floor_q});
    if (g_new > $signed({4'd0, ceil_q}))  g_new = $signed({4'd0, ceil_q});

    sm_diff    = $signed({2'b0, proc_q, 8'b0}) - $signed({2'b0, smooth_q});
    sm_prod    = $signed({{14{sm_diff[25]}}, sm_diff}) * 40'sd5243;
    smooth_new = 24'($signed({2'b0, smooth_q}) + 26'(sm_prod >>> 16));
    bs_diff    = $signed({2'b0, smooth_q}) - $signed({2'b0, base_q});
    bs_prod    = $signed({{14{bs_diff[25]}}, bs_diff}) * 40'sd1311;
    base_new   = 24'($signed({2'b0, base_q}) + 26'(bs_prod >>> 16));

    smooth_x5 = 27'(smooth_q) * 27'd5;
    base_x9   = 28'(base_q) * 28'd9;
    elapsed   = smp_q.time_ms - last_q;
    beat_now  = (base_q > 24'd65536) && ({1'b0, smooth_x5} > base_x9) &&
                (elapsed > 32'(hold_q));
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      agc_en_q <= 1'b0;
      high_q   <= 16'd39168;
      low_q    <= 16'd17920;
      attack_q <= 16'd655;
      decay_q  <= 16'd66;
      floor_q  <= 16'd1024;
      ceil_q   <= 16'd32768;
      hold_q   <= 16'd120;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_AGC_ENABLE:  agc_en_q <= cfg_data_i[0];
        REG_TARGET_HIGH: high_q   <= cfg_data_i;
        REG_TARGET_LOW:  low_q    <= cfg_data_i;
        REG_ATTACK_RATE: attack_q <= cfg_data_i;
        REG_DECAY_RATE:  decay_q  <= cfg_data_i;
        REG_GAIN_FLOOR:  floor_q  <= cfg_data_i;
        REG_GAIN_CEIL:   ceil_q   <= cfg_data_i;
        REG_BEAT_HOLD:   hold_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer and batch state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      peak_q      <= '0;
      tally_q     <= '0;
      gain_q      <= UNITY_GAIN;
      smooth_q    <= '0;
      base_q      <= '0;
      last_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) state_q <= S_ACC;
        end
        S_ACC: begin
          if (tally_q < TW'(BATCH_SAMPLES)) begin
            sum_q   <= sum_add[40] ? '1 : sum_add[39:0];
            if (sq > peak_q) peak_q <= sq;
            tally_q <= tally_q + 1'b1;
          end
          state_q <= smp_q.batch_end ? S_SCALE : S_IDLE;
        end
        S_SCALE:    state_q <= S_DIV;
        S_DIV: begin
          if (cnt_q == 6'(WORK_W - 1)) state_q <= S_SQRT_LVL;
        end
        S_SQRT_LVL: begin
          if (cnt_q == 6'(WORK_W / 2 - 1)) state_q <= S_SQRT_PK;
        end
        S_SQRT_PK: begin
          if (cnt_q == 6'(WORK_W / 2 - 1)) begin
            state_q <= (agc_en_q && level_q > AGC_MIN_LVL) ? S_GAIN_MUL : S_SMOOTH;
          end
        end
        S_GAIN_MUL: state_q <= S_CLAMP;
        S_CLAMP:    state_q <= S_STEP_MUL;
        S_STEP_MUL: state_q <= S_GAIN_UPD;
        S_GAIN_UPD: begin
          gain_q  <= g_new[15:0];
          state_q <= S_SMOOTH;
        end
        S_SMOOTH: begin
          smooth_q <= smooth_new;
          state_q  <= S_BASE;
        end
        S_BASE: begin
          base_q  <= base_new;
          state_q <= S_BEAT;
        end
        S_BEAT: begin
          if (beat_now) last_q <= smp_q.time_ms;
          res_valid_q <= 1'b1;
          sum_q       <= '0;
          peak_q      <= '0;
          tally_q     <= '0;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start_i) smp_q <= item_i;
      end
      S_SCALE: begin
        num_q <= sum_scaled;
        rem_q <= '0;
        cnt_q <= '0;
      end
      S_DIV: begin
        num_q <= num_d;
        rem_q <= rem_d;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 6'(WORK_W - 1)) begin
          rad_q  <= num_d;
          root_q <= '0;
          bit_q  <= WORK_W'(1) << (WORK_W - 2);
          cnt_q  <= '0;
        end
      end
      S_SQRT_LVL: begin
        rad_q  <= rad_d;
        root_q <= root_d;
        bit_q  <= bit_q >> 2;
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == 6'(WORK_W / 2 - 1)) begin
          level_q <= sqrt_lvl;
          rad_q   <= pk_scaled;
          root_q  <= '0;
          bit_q   <= WORK_W'(1) << (WORK_W - 2);
          cnt_q   <= '0;
        end
      end
      S_SQRT_PK: begin
        rad_q  <= rad_d;
        root_q <= root_d;
        bit_q  <= bit_q >> 2;
        cnt_q  <= cnt_q + 1'b1;
        proc_q <= level_q;
        if (cnt_q == 6'(WORK_W / 2 - 1)) pk_lvl_q <= sqrt_lvl;
      end
      S_GAIN_MUL: prod_q <= 32'(level_q) * 32'(gain_q);
      S_CLAMP: begin
        proc_q <= (proc_wide > 22'(LEVEL_MAX)) ? LEVEL_MAX : proc_wide[15:0];
      end
      S_STEP_MUL: begin
        if (proc_q > high_q) begin
          dir_dn_q <= 1'b1;
          prod_q   <= 32'(attack_q) * 32'(proc_q - high_q);
        end else if (proc_q < low_q) begin
          dir_dn_q <= 1'b0;
          prod_q   <= 32'(decay_q) * 32'(low_q - proc_q);
        end else begin
          dir_dn_q <= 1'b0;
          prod_q   <= '0;
        end
      end
      S_BEAT: begin
        res_q.level_raw    <= proc_q;
        res_q.level_smooth <= smooth_q[23:8];
        res_q.peak_level   <= pk_lvl_q;
        res_q.beat         <= beat_now;
        res_q.gain_now     <= gain_q;
      end
      default: ;
    endcase
  end

endmodule
